>>> rtl/core/vrp_pkg.sv
// Package for the video register port: request/result structs and decode codes.
// No dependencies; used by vrp_exec and video_register_port.
`timescale 1ns / 1ps

package vrp_pkg;

    // request modes
    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_VBLANK = 2'd2;

    // register offsets from the register base
    localparam logic [2:0] OFS_CONTROL = 3'd0;
    localparam logic [2:0] OFS_MASK    = 3'd1;
    localparam logic [2:0] OFS_STATUS  = 3'd2;
    localparam logic [2:0] OFS_OAMADDR = 3'd3;
    localparam logic [2:0] OFS_OAMDATA = 3'd4;
    localparam logic [2:0] OFS_SCROLL  = 3'd5;
    localparam logic [2:0] OFS_ADDR    = 3'd6;
    localparam logic [2:0] OFS_DATA    = 3'd7;

    // memory write targets
    localparam logic [2:0] TGT_NONE      = 3'd0;
    localparam logic [2:0] TGT_PATTERN   = 3'd1;
    localparam logic [2:0] TGT_NAMETABLE = 3'd2;
    localparam logic [2:0] TGT_PALETTE   = 3'd3;
    localparam logic [2:0] TGT_OAM       = 3'd4;

    localparam logic [7:0] STATUS_RESET  = 8'h80;
    localparam logic [5:0] PALETTE_PAGE  = 6'h3F;

    // configuration register indexes
    localparam logic [0:0] CFG_MIRROR = 1'd0;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
    } vrp_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  write_target;
        logic [12:0] write_addr;
        logic [7:0]  write_value;
        logic        palette_low_copy;
        logic [7:0]  control_out;
        logic [7:0]  mask_out;
        logic [7:0]  scroll_x_out;
        logic [7:0]  scroll_y_out;
        logic [7:0]  held_scroll_x_out;
    } vrp_out_t;

endpackage

>>> rtl/core/vrp_exec.sv
// Register file and request decode of the video register port.
// Holds the unit state, forms one result per request; uses vrp_pkg.
`timescale 1ns / 1ps

module vrp_exec (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            mirror_vertical,
    input  vrp_pkg::vrp_in_t  request,
    output vrp_pkg::vrp_out_t result
);

    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  oam_pointer_reg, oam_pointer_next;
    logic [15:0] video_address_reg, video_address_next;
    logic        second_write_reg, second_write_next;
    logic [7:0]  scroll_x_reg, scroll_x_next;
    logic [7:0]  scroll_y_reg, scroll_y_next;
    logic [7:0]  held_scroll_x_reg, held_scroll_x_next;

    logic [13:0] masked_addr;
    logic        nt_select;

    assign masked_addr = video_address_reg[13:0];
    // horizontal mirroring pairs tables by bit 11, vertical by bit 10
    assign nt_select   = mirror_vertical ? masked_addr[10] : masked_addr[11];

    always_comb
    begin
        control_next       = control_reg;
        mask_next          = mask_reg;
        status_next        = status_reg;
        oam_pointer_next   = oam_pointer_reg;
        video_address_next = video_address_reg;
        second_write_next  = second_write_reg;
        scroll_x_next      = scroll_x_reg;
        scroll_y_next      = scroll_y_reg;
        held_scroll_x_next = held_scroll_x_reg;

        result.read_data        = 8'd0;
        result.write_target     = vrp_pkg::TGT_NONE;
        result.write_addr       = 13'd0;
        result.write_value      = 8'd0;
        result.palette_low_copy = 1'b0;

        case (request.mode)
            vrp_pkg::MODE_READ:
            begin
                if (request.reg_offset == vrp_pkg::OFS_STATUS)
                    result.read_data = status_reg;
            end
            vrp_pkg::MODE_WRITE:
            begin
                case (request.reg_offset)
                    vrp_pkg::OFS_CONTROL: control_next = request.write_data;
                    vrp_pkg::OFS_MASK:    mask_next = request.write_data;
                    vrp_pkg::OFS_OAMADDR: oam_pointer_next = request.write_data;
                    vrp_pkg::OFS_OAMDATA:
                    begin
                        result.write_target = vrp_pkg::TGT_OAM;
                        result.write_addr   = {5'd0, oam_pointer_reg};
                        result.write_value  = request.write_data;
                        oam_pointer_next    = oam_pointer_reg + 8'd1;
                    end
                    vrp_pkg::OFS_SCROLL:
                    begin
                        if (!second_write_reg)
                        begin
                            scroll_x_next = request.write_data;
                            if (request.write_data != 8'd0)
                                held_scroll_x_next = request.write_data;
                        end
                        else
                        begin
                            scroll_y_next = request.write_data;
                        end
                        second_write_next = ~second_write_reg;
                    end
                    vrp_pkg::OFS_ADDR:
                    begin
                        if (!second_write_reg)
                            video_address_next = {request.write_data, video_address_reg[7:0]};
                        else
                            video_address_next = {video_address_reg[15:8], request.write_data};
                        second_write_next = ~second_write_reg;
                    end
                    vrp_pkg::OFS_DATA:
                    begin
                        if (!masked_addr[13])
                        begin
                            result.write_target = vrp_pkg::TGT_PATTERN;
                            result.write_addr   = masked_addr[12:0];
                            result.write_value  = request.write_data;
                        end
                        else if (masked_addr[13:8] != vrp_pkg::PALETTE_PAGE)
                        begin
                            result.write_target = vrp_pkg::TGT_NAMETABLE;
                            result.write_addr   = {2'd0, nt_select, masked_addr[9:0]};
                            result.write_value  = request.write_data;
                        end
                        else if (masked_addr[7:5] == 3'd0)
                        begin
                            result.write_target     = vrp_pkg::TGT_PALETTE;
                            result.write_addr       = {8'd0, masked_addr[4:0]};
                            result.write_value      = request.write_data;
                            // sprite backdrop entries mirror the background ones
                            result.palette_low_copy = masked_addr[4]
                                                      & (masked_addr[1:0] == 2'd0);
                        end
                        // step across a row when control bit 2 is set
                        video_address_next = video_address_reg
                                             + (control_reg[2] ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
            vrp_pkg::MODE_VBLANK:
            begin
                status_next = {request.write_data[0], status_reg[6:0]};
            end
            default: ;
        endcase

        result.control_out       = control_next;
        result.mask_out          = mask_next;
        result.scroll_x_out      = scroll_x_next;
        result.scroll_y_out      = scroll_y_next;
        result.held_scroll_x_out = held_scroll_x_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg       <= 8'd0;
            mask_reg          <= 8'd0;
            status_reg        <= vrp_pkg::STATUS_RESET;
            oam_pointer_reg   <= 8'd0;
            video_address_reg <= 16'd0;
            second_write_reg  <= 1'b0;
            scroll_x_reg      <= 8'd0;
            scroll_y_reg      <= 8'd0;
            held_scroll_x_reg <= 8'd0;
        end
        else if (step)
        begin
            control_reg       <= control_next;
            mask_reg          <= mask_next;
            status_reg        <= status_next;
            oam_pointer_reg   <= oam_pointer_next;
            video_address_reg <= video_address_next;
            second_write_reg  <= second_write_next;
            scroll_x_reg      <= scroll_x_next;
            scroll_y_reg      <= scroll_y_next;
            held_scroll_x_reg <= held_scroll_x_next;
        end
    end

endmodule

>>> rtl/core/video_register_port.sv
// Top level of the video register port: request and result registers, APB port.
// Depends on vrp_pkg and vrp_exec.
`timescale 1ns / 1ps

// Usage
//   in_valid/in_stall/in_data carry one bus request (read, write or vblank
//   event at one of eight register offsets). A request is taken at a rising
//   edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_data carry exactly one result per request: read
//   data, an optional memory write (pattern, nametable, palette or object
//   memory) and the register values after the request.
//   The request register holds a request, then decode and state update
//   load the result register. Throughput is one request per cycle when
//   out_stall is low, set by the single decode pass between the registers.
//   When the receiver stalls, the result holds; one more request is still
//   taken into the request register, after which in_stall rises until the
//   result is taken.
//   Reset clears both stages, all unit registers to zero, status to vblank
//   set, and selects horizontal mirroring.
//   The APB port holds mirror_vertical at byte address 0; write it only
//   while no request is in flight.

module video_register_port (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vrp_pkg::vrp_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output vrp_pkg::vrp_out_t   out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic               req_valid_reg;
    vrp_pkg::vrp_in_t   req_data_reg;
    logic               res_valid_reg;
    vrp_pkg::vrp_out_t  res_data_reg;
    logic               mirror_vertical_reg;

    logic               step;
    logic               in_take;
    logic               cfg_hit;
    vrp_pkg::vrp_out_t  exec_result;

    // result slot frees when empty or being taken this edge
    assign step     = req_valid_reg & (~res_valid_reg | ~out_stall);
    // request slot is busy only when it holds a request that cannot advance
    assign in_stall = req_valid_reg & res_valid_reg & out_stall;
    assign in_take  = in_valid & ~in_stall;

    assign cfg_hit  = (paddr[2:2] == vrp_pkg::CFG_MIRROR);

    vrp_exec u_exec (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .mirror_vertical (mirror_vertical_reg),
        .request         (req_data_reg),
        .result          (exec_result)
    );

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (in_take)
            req_valid_reg <= 1'b1;
        else if (step)
            req_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            req_data_reg <= in_data;
    end

    // result stage: load on step, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step)
            res_valid_reg <= 1'b1;
        else if (~out_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_data_reg <= exec_result;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_data_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mirror_vertical_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && cfg_hit)
            mirror_vertical_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = cfg_hit ? {31'd0, mirror_vertical_reg} : 32'd0;

endmodule

>>> tb/video_register_port_tb.sv
// Self-checking testbench for the video register port: directed and random bus requests,
// random stalls on both channels, and mirroring changes over the APB port.
// Depends on vrp_pkg and the video_register_port RTL.
`timescale 1ns / 1ps

module video_register_port_tb;

    // mode 3 has no name in the package; the block ignores it
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TAIL_CYCLES    = 8;
    localparam int         PHASE_ITEMS    = 400;

    // Tracks the register file of the block and holds the results that
    // accepted requests must produce, oldest first.
    class port_scoreboard;
        logic        mirror_vertical;
        logic [7:0]  control;
        logic [7:0]  mask;
        logic [7:0]  status;
        logic [7:0]  oam_ptr;
        logic [15:0] vaddr;
        logic        toggle;
        logic [7:0]  scroll_x;
        logic [7:0]  scroll_y;
        logic [7:0]  held_x;
        vrp_pkg::vrp_out_t expected_results[$];
        int          errors;
        int          checked;

        function new();
            mirror_vertical = 1'b0;
            control         = '0;
            mask            = '0;
            status          = vrp_pkg::STATUS_RESET;
            oam_ptr         = '0;
            vaddr           = '0;
            toggle          = 1'b0;
            scroll_x        = '0;
            scroll_y        = '0;
            held_x          = '0;
            errors          = 0;
            checked         = 0;
        endfunction

        function void report(string what, int exp_v, int act_v);
            errors++;
            if (errors <= 10)
                $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, exp_v, act_v);
        endfunction

        // Apply one request to the tracked registers and return its result.
        function vrp_pkg::vrp_out_t step_registers(vrp_pkg::vrp_in_t rq);
            vrp_pkg::vrp_out_t r;
            logic [13:0] a;
            logic [7:0]  d;
            logic        bank;
            r = '0;
            a = vaddr[13:0];
            d = rq.write_data;
            case (rq.mode)
                vrp_pkg::MODE_READ:
                    if (rq.reg_offset == vrp_pkg::OFS_STATUS)
                        r.read_data = status;
                vrp_pkg::MODE_WRITE:
                    case (rq.reg_offset)
                        vrp_pkg::OFS_CONTROL: control = d;
                        vrp_pkg::OFS_MASK:    mask = d;
                        vrp_pkg::OFS_OAMADDR: oam_ptr = d;
                        vrp_pkg::OFS_OAMDATA:
                        begin
                            r.write_target = vrp_pkg::TGT_OAM;
                            r.write_addr   = {5'd0, oam_ptr};
                            r.write_value  = d;
                            oam_ptr        = oam_ptr + 8'd1;
                        end
                        vrp_pkg::OFS_SCROLL:
                        begin
                            if (!toggle)
                            begin
                                if (d != 8'd0)
                                    held_x = d;
                                scroll_x = d;
                            end
                            else
                                scroll_y = d;
                            toggle = ~toggle;
                        end
                        vrp_pkg::OFS_ADDR:
                        begin
                            if (!toggle)
                                vaddr[15:8] = d;
                            else
                                vaddr[7:0] = d;
                            toggle = ~toggle;
                        end
                        vrp_pkg::OFS_DATA:
                        begin
                            if (a < 14'h2000)
                            begin
                                r.write_target = vrp_pkg::TGT_PATTERN;
                                r.write_addr   = a[12:0];
                                r.write_value  = d;
                            end
                            else if (a < 14'h3F00)
                            begin
                                // horizontal pairs quadrants by bit 11, vertical by bit 10
                                bank           = mirror_vertical ? a[10] : a[11];
                                r.write_target = vrp_pkg::TGT_NAMETABLE;
                                r.write_addr   = {2'b00, bank, a[9:0]};
                                r.write_value  = d;
                            end
                            else if (a < 14'h3F20)
                            begin
                                r.write_target     = vrp_pkg::TGT_PALETTE;
                                r.write_addr       = {8'd0, a[4:0]};
                                r.write_value      = d;
                                r.palette_low_copy = a[4] && (a[1:0] == 2'b00);
                            end
                            vaddr = vaddr + (control[2] ? 16'd32 : 16'd1);
                        end
                        default: ;
                    endcase
                vrp_pkg::MODE_VBLANK:
                    status[7] = d[0];
                default: ;
            endcase
            r.control_out       = control;
            r.mask_out          = mask;
            r.scroll_x_out      = scroll_x;
            r.scroll_y_out      = scroll_y;
            r.held_scroll_x_out = held_x;
            return r;
        endfunction

        function void note_request(vrp_pkg::vrp_in_t rq);
            expected_results.push_back(step_registers(rq));
        endfunction

        function void check_result(vrp_pkg::vrp_out_t got);
            vrp_pkg::vrp_out_t want;
            if (expected_results.size() == 0)
            begin
                report("result with no request pending", 0, 1);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.read_data !== want.read_data)
                report("read_data", int'(want.read_data), int'(got.read_data));
            if (got.write_target !== want.write_target)
                report("write_target", int'(want.write_target), int'(got.write_target));
            if (got.write_addr !== want.write_addr)
                report("write_addr", int'(want.write_addr), int'(got.write_addr));
            if (got.write_value !== want.write_value)
                report("write_value", int'(want.write_value), int'(got.write_value));
            if (got.palette_low_copy !== want.palette_low_copy)
                report("palette_low_copy", int'(want.palette_low_copy),
                       int'(got.palette_low_copy));
            if (got.control_out !== want.control_out)
                report("control_out", int'(want.control_out), int'(got.control_out));
            if (got.mask_out !== want.mask_out)
                report("mask_out", int'(want.mask_out), int'(got.mask_out));
            if (got.scroll_x_out !== want.scroll_x_out)
                report("scroll_x_out", int'(want.scroll_x_out), int'(got.scroll_x_out));
            if (got.scroll_y_out !== want.scroll_y_out)
                report("scroll_y_out", int'(want.scroll_y_out), int'(got.scroll_y_out));
            if (got.held_scroll_x_out !== want.held_scroll_x_out)
                report("held_scroll_x_out", int'(want.held_scroll_x_out),
                       int'(got.held_scroll_x_out));
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    vrp_pkg::vrp_in_t  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    vrp_pkg::vrp_out_t out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    port_scoreboard sb = new();

    int  tx_pct      = 0;   // chance per request of a sender gap
    int  rx_pct      = 0;   // chance per cycle of a receiver stall burst
    int  rx_left     = 0;
    int  idle_cycles = 0;
    int  sent        = 0;   // accepted requests, apart from the unused mode and status writes
    bit  gen_toggle  = 1'b0;

    video_register_port i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sample both channels with the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // Receiver stalls come in bursts; rx_left counts the stall cycles still to come.
    always @(posedge clk)
    begin
        if (rx_left > 0)
        begin
            out_stall <= 1'b1;
            rx_left   <= rx_left - 1;
        end
        else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct)
        begin
            out_stall <= 1'b1;
            rx_left   <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    // Drop the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Present one request and hold it until taken; then maybe idle the sender.
    task automatic send_request(input logic [1:0] mode, input logic [2:0] ofs,
                                input logic [7:0] data);
        vrp_pkg::vrp_in_t rq;
        rq.mode       = mode;
        rq.reg_offset = ofs;
        rq.write_data = data;
        in_data  <= rq;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        // scroll and address writes share one toggle; track it for realignment
        if (mode == vrp_pkg::MODE_WRITE && (ofs == vrp_pkg::OFS_SCROLL || ofs == vrp_pkg::OFS_ADDR))
            gen_toggle = ~gen_toggle;
        if (!(mode == MODE_UNUSED || (mode == vrp_pkg::MODE_WRITE && ofs == vrp_pkg::OFS_STATUS)))
            sent++;
        if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every expected result has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 3'(4 * vrp_pkg::CFG_MIRROR);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Change mirroring only with nothing in flight, then read it back.
    task automatic set_mirror(input logic v);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, {31'd0, v}, rd);
        sb.mirror_vertical = v;
        apb_access(1'b0, '0, rd);
        if (rd[0] !== v)
            sb.report("mirror_vertical readback", int'(v), int'(rd[0]));
    endtask

    // One random burst: mostly well-formed register sequences, some noise.
    task automatic random_burst();
        logic [7:0] hi;
        logic [7:0] lo;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                // realign the toggle so the address pair lands high then low
                if (gen_toggle)
                    send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_SCROLL,
                                 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                    send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_CONTROL,
                                 8'($urandom_range(0, 255)));
                case ($urandom_range(0, 3))
                    0:       hi = 8'($urandom_range(8'h00, 8'h1F));
                    1:       hi = 8'($urandom_range(8'h20, 8'h3E));
                    2:       hi = 8'h3F;
                    default: hi = 8'($urandom_range(0, 255));
                endcase
                if (hi == 8'h3F && $urandom_range(0, 1))
                    lo = 8'($urandom_range(0, 31));
                else
                    lo = 8'($urandom_range(0, 255));
                send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, hi);
                send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, lo);
                repeat ($urandom_range(1, 8))
                    send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_DATA,
                                 8'($urandom_range(0, 255)));
            end
            4:
            begin
                send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_OAMADDR,
                             8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 6))
                    send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_OAMDATA,
                                 8'($urandom_range(0, 255)));
            end
            5:
            begin
                if (gen_toggle)
                    send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR,
                                 8'($urandom_range(0, 255)));
                send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_SCROLL,
                             ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
                send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_SCROLL,
                             8'($urandom_range(0, 255)));
            end
            6:
            begin
                send_request(vrp_pkg::MODE_VBLANK, 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)));
                send_request(vrp_pkg::MODE_READ, vrp_pkg::OFS_STATUS,
                             8'($urandom_range(0, 255)));
            end
            default:
                send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)));
        endcase
    endtask

    initial
    begin
        logic mirror_plan[4];
        int   tx_plan[4];
        int   rx_plan[4];
        int   target;
        mirror_plan = '{1'b1, 1'b0, 1'b1, 1'b0};
        tx_plan     = '{20, 35, 10, 0};
        rx_plan     = '{20, 30, 10, 0};

        // hold reset low, then release it at an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_pct = 15;
        rx_pct = 15;
        set_mirror(1'b0);

        // status reads and vblank events
        send_request(vrp_pkg::MODE_READ, vrp_pkg::OFS_STATUS, 8'h00);
        send_request(vrp_pkg::MODE_VBLANK, vrp_pkg::OFS_CONTROL, 8'h00);
        send_request(vrp_pkg::MODE_READ, vrp_pkg::OFS_STATUS, 8'hFF);
        send_request(vrp_pkg::MODE_VBLANK, vrp_pkg::OFS_DATA, 8'hFF);
        // ignored requests: the unused mode and a status write
        send_request(MODE_UNUSED, vrp_pkg::OFS_DATA, 8'hFF);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_STATUS, 8'hFF);
        send_request(vrp_pkg::MODE_READ, vrp_pkg::OFS_DATA, 8'h00);
        // control and mask extremes
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_CONTROL, 8'hFF);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_CONTROL, 8'h00);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_MASK, 8'hFF);
        // object pointer wraps past the top
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_OAMADDR, 8'hFF);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_OAMDATA, 8'hAA);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_OAMDATA, 8'h55);
        // zero scroll leaves the held value alone, nonzero updates it
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_SCROLL, 8'h00);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_SCROLL, 8'hFF);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_SCROLL, 8'h7F);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_SCROLL, 8'h00);
        // palette entry with a low copy, then its neighbor
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, 8'h3F);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, 8'h10);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_DATA, 8'h12);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_DATA, 8'h34);
        // top of the 16-bit address: no write, then the step wraps to zero
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, 8'hFF);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, 8'hFF);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_DATA, 8'h00);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_DATA, 8'hFF);
        // nametable write in the last quadrant
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, 8'h2C);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_ADDR, 8'h05);
        send_request(vrp_pkg::MODE_WRITE, vrp_pkg::OFS_DATA, 8'hC3);

        // random phases; the last one runs with no idling on either side
        for (int ph = 0; ph < 4; ph++)
        begin
            set_mirror(mirror_plan[ph]);
            tx_pct = tx_plan[ph];
            rx_pct = rx_plan[ph];
            target = sent + PHASE_ITEMS;
            while (sent < target)
                random_burst();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_results.size() != 0)
            sb.report("results still expected at end", 0, sb.expected_results.size());

        $display("Ran %0d requests over both mirroring modes; %0d results checked.",
                 sent, sb.checked);
        $display("Mismatches counted: %0d", sb.errors);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/vrp_pkg.sv
rtl/core/vrp_exec.sv
rtl/core/video_register_port.sv
tb/video_register_port_tb.sv
